>>> rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the breakpoint table: action and status
// codes, controller states, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

    localparam logic [31:0] TRAP_WORD  = 32'h0010_0073;
    localparam logic [1:0]  ALIGN_MASK = 2'h3;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_MEMFAIL    = 3'd4,
        ST_NOSLOT     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LAST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take_in;
        logic look;
        logic read_last;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_valid;
        logic go_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/core/bpt_in_if.sv
// ----------------------------------------------------------------------------
// bpt_in_if
// Request channel of the breakpoint table: one action item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] address;
    logic [3:0]  slot;
    logic [31:0] original_word;
    logic        mem_ok;

    modport source (
        output valid, action, address, slot, original_word, mem_ok,
        input  ready
    );

    modport sink (
        input  valid, action, address, slot, original_word, mem_ok,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/bpt_out_if.sv
// ----------------------------------------------------------------------------
// bpt_out_if
// Result channel of the breakpoint table: one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  assigned_slot;
    logic [4:0]  entry_total;
    logic        hit;
    logic        write_request;
    logic [31:0] write_address;
    logic [31:0] write_word;

    modport source (
        output valid, status, assigned_slot, entry_total, hit,
               write_request, write_address, write_word,
        input  ready
    );

    modport sink (
        input  valid, status, assigned_slot, entry_total, hit,
               write_request, write_address, write_word,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/breakpoint_table.sv
// ----------------------------------------------------------------------------
// breakpoint_table
// Table of up to DEPTH software breakpoints: add, delete by slot, check hit.
//
// i_in carries one action per transfer (add, delete, check); o_out returns
// exactly one result per action, in order. Adds and checks compare the
// address against every held entry at once, one comparator per lane, and the
// match vector is registered before the decision.
// An add or check goes from the lookup state to the commit state; a delete of
// a held slot passes the last-entry state between them, reading the freed slot
// and then the last entry through the single port of the entry memory.
// The controller takes a new item only once the previous one has committed.
// Reset clears the entry count and the result valid flag; entries need no
// clearing. When the receiver stalls, the result holds in its register; the
// next item is still taken and worked up to its commit, where it waits until
// the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_table #(
    parameter int DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bpt_in_if.sink     i_in,
    bpt_out_if.source  o_out
);
    import bpt_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    bpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bpt_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/core/bpt_ctrl.sv
// ----------------------------------------------------------------------------
// bpt_ctrl
// Sequencer of the breakpoint table: takes an item, runs the lookup, reads
// the last entry for a delete of a held slot, and commits once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  bpt_pkg::t_dp_sts i_sts,
    output bpt_pkg::t_ctl_cmd o_cmd
);
    import bpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = i_sts.go_last ? S_LAST : S_DONE;
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take_in = 1'b1;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
            end
            S_LAST: begin
                o_cmd.read_last = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/bpt_dpath.sv
// ----------------------------------------------------------------------------
// bpt_dpath
// Datapath of the breakpoint table: address lanes with one comparator each,
// an entry memory holding address and saved word, the entry count and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_dpath #(
    parameter int DEPTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bpt_pkg::t_ctl_cmd  i_cmd,
    output bpt_pkg::t_dp_sts   o_sts,
    bpt_in_if.sink             i_in,
    bpt_out_if.source          o_out
);
    import bpt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = (CW > 4) ? CW : 4;

    logic [1:0]       r_action;
    logic [31:0]      r_addr;
    logic [3:0]       r_slot;
    logic [31:0]      r_orig;
    logic             r_mem_ok;
    logic [CW-1:0]    r_count;
    logic [DEPTH-1:0] r_match;
    logic [29:0]      r_lane [DEPTH];
    logic [61:0]      r_mem  [DEPTH];
    logic [61:0]      r_rd;
    logic [29:0]      r_sav_addr;
    logic [31:0]      r_sav_word;

    logic             r_o_valid;
    t_status          r_o_status;
    logic [3:0]       r_o_assigned;
    logic [4:0]       r_o_total;
    logic             r_o_hit;
    logic             r_o_wreq;
    logic [31:0]      r_o_waddr;
    logic [31:0]      r_o_wword;

    logic [DEPTH-1:0] w_match;
    logic             w_slot_ok;
    logic             w_full;
    logic             w_aligned;
    logic             w_hit;
    logic             w_go_last;
    logic [IW-1:0]    w_slot_idx;
    logic [IW-1:0]    w_cnt_idx;
    logic [IW-1:0]    w_last_idx;

    t_status          n_status;
    logic [3:0]       n_assigned;
    logic             n_hit;
    logic             n_wreq;
    logic [31:0]      n_waddr;
    logic [31:0]      n_wword;
    logic [CW-1:0]    n_count;
    logic             w_add_commit;
    logic             w_del_commit;

    assign w_slot_ok  = SW'(r_slot) < SW'(r_count);
    assign w_full     = r_count == CW'(DEPTH);
    assign w_aligned  = (r_addr[1:0] & ALIGN_MASK) == 2'b00;
    assign w_hit      = |r_match;
    assign w_go_last  = (r_action == ACT_DELETE) && w_slot_ok;
    assign w_slot_idx = IW'(r_slot);
    assign w_cnt_idx  = IW'(r_count);
    assign w_last_idx = IW'(r_count - CW'(1));

    assign i_in.ready     = i_cmd.take_in;
    assign o_sts.in_valid = i_in.valid;
    assign o_sts.go_last  = w_go_last;
    assign o_sts.out_free = !r_o_valid || o_out.ready;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (r_lane[i] == r_addr[31:2]) && (r_count > CW'(i));
        end
    end

    always_comb begin
        n_status     = ST_OK;
        n_assigned   = 4'd0;
        n_hit        = 1'b0;
        n_wreq       = 1'b0;
        n_waddr      = 32'd0;
        n_wword      = 32'd0;
        n_count      = r_count;
        w_add_commit = 1'b0;
        w_del_commit = 1'b0;
        case (r_action)
            ACT_ADD: begin
                if (!w_aligned) begin
                    n_status = ST_MISALIGNED;
                end else if (w_hit) begin
                    n_status = ST_DUPLICATE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else if (!r_mem_ok) begin
                    n_status = ST_MEMFAIL;
                end else begin
                    w_add_commit = 1'b1;
                    n_assigned   = 4'(r_count);
                    n_count      = r_count + CW'(1);
                    n_wreq       = 1'b1;
                    n_waddr      = r_addr;
                    n_wword      = TRAP_WORD;
                end
            end
            ACT_DELETE: begin
                if (!w_slot_ok) begin
                    n_status = ST_NOSLOT;
                end else begin
                    w_del_commit = 1'b1;
                    n_count      = r_count - CW'(1);
                    n_wreq       = 1'b1;
                    n_waddr      = {r_sav_addr, 2'b00};
                    n_wword      = r_sav_word;
                end
            end
            ACT_CHECK: begin
                n_hit = w_aligned && w_hit;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in && i_in.valid) begin
            r_action <= i_in.action;
            r_addr   <= i_in.address;
            r_slot   <= i_in.slot;
            r_orig   <= i_in.original_word;
            r_mem_ok <= i_in.mem_ok;
        end
        if (i_cmd.look) begin
            r_match <= w_match;
        end
        if (i_cmd.read_last) begin
            r_sav_addr <= r_rd[61:32];
            r_sav_word <= r_rd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look && w_go_last) begin
            r_rd <= r_mem[w_slot_idx];
        end else if (i_cmd.read_last) begin
            r_rd <= r_mem[w_last_idx];
        end
        if (i_cmd.finish && w_add_commit) begin
            r_mem[w_cnt_idx] <= {r_addr[31:2], r_orig};
        end else if (i_cmd.finish && w_del_commit) begin
            r_mem[w_slot_idx] <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_add_commit) begin
            r_lane[w_cnt_idx] <= r_addr[31:2];
        end else if (i_cmd.finish && w_del_commit) begin
            r_lane[w_slot_idx] <= r_rd[61:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_status   <= n_status;
            r_o_assigned <= n_assigned;
            r_o_total    <= 5'(n_count);
            r_o_hit      <= n_hit;
            r_o_wreq     <= n_wreq;
            r_o_waddr    <= n_waddr;
            r_o_wword    <= n_wword;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.assigned_slot = r_o_assigned;
    assign o_out.entry_total   = r_o_total;
    assign o_out.hit           = r_o_hit;
    assign o_out.write_request = r_o_wreq;
    assign o_out.write_address = r_o_waddr;
    assign o_out.write_word    = r_o_wword;

endmodule

`default_nettype wire
